// ----- src/srd_pkg.sv -----
// ---------------------------------------------------------------------------
// srd_pkg
// Shared types and constants for the refraction direction pipeline.
// ---------------------------------------------------------------------------
package srd_pkg;

  localparam int IN_W  = 16;
  localparam int OUT_W = 18;
  localparam int CFG_W = 32;
  localparam int ADDR_W = 3;

  localparam logic REG_MATERIAL = 1'b0;
  localparam logic REG_ROUGH    = 1'b1;

  localparam logic [15:0] MATERIAL_RESET = 16'd24576;
  localparam logic [14:0] ROUGH_RESET    = 15'd0;

  typedef struct packed {
    logic en;
    logic valid;
  } pipe_ctl_t;

endpackage

// ----- src/srd_sqrt.sv -----
// ---------------------------------------------------------------------------
// srd_sqrt
// Pipelined integer floor square root, one root bit per register stage,
// with a sideband word that travels alongside.
// ---------------------------------------------------------------------------
module srd_sqrt #(
  parameter int VW = 32,
  parameter int SW = 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  srd_pkg::pipe_ctl_t       ctl,
  input  logic [VW-1:0]            val,
  input  logic [SW-1:0]            side_in,
  output logic                     valid_out,
  output logic [(VW+1)/2-1:0]      root,
  output logic [SW-1:0]            side_out
);

  localparam int RW = (VW + 1) / 2;
  localparam int PW = 2 * RW;
  localparam int TW = RW + 2;

  logic [PW-1:0] v_s  [RW+1];
  logic [TW-1:0] r_s  [RW+1];
  logic [RW-1:0] q_s  [RW+1];
  logic [SW-1:0] sd_s [RW+1];
  logic          vl_s [RW+1];

  assign v_s[0]  = PW'(val);
  assign r_s[0]  = '0;
  assign q_s[0]  = '0;
  assign sd_s[0] = side_in;
  assign vl_s[0] = ctl.valid;

  for (genvar j = 0; j < RW; j++) begin : g_stage
    logic [TW-1:0] sh;
    logic [TW-1:0] trial;
    logic          take;

    assign sh    = {r_s[j][TW-3:0], v_s[j][PW-1 -: 2]};
    assign trial = {q_s[j], 2'b01};
    assign take  = (sh >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vl_s[j+1] <= 1'b0;
      end else if (ctl.en) begin
        vl_s[j+1] <= vl_s[j];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        v_s[j+1]  <= {v_s[j][PW-3:0], 2'b00};
        r_s[j+1]  <= take ? (sh - trial) : sh;
        q_s[j+1]  <= {q_s[j][RW-2:0], take};
        sd_s[j+1] <= sd_s[j];
      end
    end
  end

  assign valid_out = vl_s[RW];
  assign root      = q_s[RW];
  assign side_out  = sd_s[RW];

endmodule

// ----- src/srd_div.sv -----
// ---------------------------------------------------------------------------
// srd_div
// Pipelined restoring divider, one quotient bit per register stage, LANES
// numerators over one shared divisor, with a sideband word alongside.
// ---------------------------------------------------------------------------
module srd_div #(
  parameter int NW    = 30,
  parameter int DW    = 16,
  parameter int QW    = 15,
  parameter int LANES = 1,
  parameter int SW    = 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  srd_pkg::pipe_ctl_t           ctl,
  input  logic [LANES-1:0][NW-1:0]     num,
  input  logic [DW-1:0]                den,
  input  logic [SW-1:0]                side_in,
  output logic                         valid_out,
  output logic [LANES-1:0][QW-1:0]     quo,
  output logic [SW-1:0]                side_out
);

  logic [LANES-1:0][DW-1:0] rm_s [QW+1];
  logic [LANES-1:0][QW-1:0] lo_s [QW+1];
  logic [DW-1:0]            dn_s [QW+1];
  logic [SW-1:0]            sd_s [QW+1];
  logic                     vl_s [QW+1];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rm_s[0][l] = DW'(num[l][NW-1:QW]);
      lo_s[0][l] = num[l][QW-1:0];
    end
  end

  assign dn_s[0] = den;
  assign sd_s[0] = side_in;
  assign vl_s[0] = ctl.valid;

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic [LANES-1:0][DW-1:0] rm_next;
    logic [LANES-1:0][QW-1:0] lo_next;

    always_comb begin
      logic [DW:0] sh;
      for (int l = 0; l < LANES; l++) begin
        sh = {rm_s[j][l], lo_s[j][l][QW-1]};
        if (sh >= {1'b0, dn_s[j]}) begin
          rm_next[l] = DW'(sh - {1'b0, dn_s[j]});
          lo_next[l] = {lo_s[j][l][QW-2:0], 1'b1};
        end else begin
          rm_next[l] = DW'(sh);
          lo_next[l] = {lo_s[j][l][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vl_s[j+1] <= 1'b0;
      end else if (ctl.en) begin
        vl_s[j+1] <= vl_s[j];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        rm_s[j+1] <= rm_next;
        lo_s[j+1] <= lo_next;
        dn_s[j+1] <= dn_s[j];
        sd_s[j+1] <= sd_s[j];
      end
    end
  end

  assign valid_out = vl_s[QW];
  assign quo       = lo_s[QW];
  assign side_out  = sd_s[QW];

endmodule

// ----- src/snell_refract_direction.sv -----
// ---------------------------------------------------------------------------
// snell_refract_direction
// Snell refracted ray direction with a roughness perturbation, fixed point.
// The depth is set by the bit-per-stage roots and dividers in series.
// Throughput one request per cycle; the whole pipeline holds on a stall.
// Synchronous reset clears all valid bits and restores the configuration registers.
// ---------------------------------------------------------------------------
module snell_refract_direction #(
  parameter int FRAC_BITS = 14
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [srd_pkg::ADDR_W-1:0]         paddr,
  input  logic [srd_pkg::CFG_W-1:0]          pwdata,
  output logic [srd_pkg::CFG_W-1:0]          prdata,
  output logic                               pready,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [srd_pkg::IN_W-1:0]    dir_x,
  input  logic signed [srd_pkg::IN_W-1:0]    dir_y,
  input  logic signed [srd_pkg::IN_W-1:0]    dir_z,
  input  logic signed [srd_pkg::IN_W-1:0]    norm_x,
  input  logic signed [srd_pkg::IN_W-1:0]    norm_y,
  input  logic signed [srd_pkg::IN_W-1:0]    norm_z,
  input  logic                               front_face,
  input  logic [srd_pkg::IN_W-1:0]           current_index,
  input  logic signed [srd_pkg::IN_W-1:0]    rand_x,
  input  logic signed [srd_pkg::IN_W-1:0]    rand_y,
  input  logic signed [srd_pkg::IN_W-1:0]    rand_z,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [srd_pkg::OUT_W-1:0]   out_x,
  output logic signed [srd_pkg::OUT_W-1:0]   out_y,
  output logic signed [srd_pkg::OUT_W-1:0]   out_z,
  output logic                               refracted_ok
);

  localparam int F      = FRAC_BITS;
  localparam int IW     = srd_pkg::IN_W;
  localparam int OW     = srd_pkg::OUT_W;
  localparam int DOT_W  = 2 * IW + 2;
  localparam int CI_W   = DOT_W + 1 - F;
  localparam int CS_W   = 2 * CI_W - F;
  localparam int OM_W   = ((CS_W > F + 2) ? CS_W : F + 2) + 1;
  localparam int RATIO_W = F + 4;
  localparam int R2_W   = 2 * RATIO_W - F;
  localparam int SP_W   = R2_W + 1 + OM_W;
  localparam int S_W    = SP_W - F;
  localparam int SQ_W   = S_W + F;
  localparam int CT_W   = (SQ_W + 1) / 2;
  localparam int RCP_W  = RATIO_W + 1 + CI_W;
  localparam int RC_W   = RCP_W - F;
  localparam int K_W    = ((RC_W > CT_W + 1) ? RC_W : CT_W + 1) + 1;
  localparam int NKP_W  = IW + K_W;
  localparam int NK_W   = NKP_W - F;
  localparam int DRP_W  = IW + RATIO_W + 1;
  localparam int DR_W   = DRP_W - F;
  localparam int RN_W   = F + 2;
  localparam int RRP_W  = RN_W + 16;
  localparam int RR_W   = RRP_W - F;
  localparam int M1_W   = (NK_W > DR_W) ? NK_W : DR_W;
  localparam int SUM_W  = ((M1_W > RR_W) ? M1_W : RR_W) + 2;

  localparam logic signed [OM_W-1:0] ONE_OM = {{(OM_W-F-1){1'b0}}, 1'b1, {F{1'b0}}};
  localparam logic signed [S_W-1:0]  ONE_S  = {{(S_W-F-1){1'b0}}, 1'b1, {F{1'b0}}};

  typedef struct packed {
    logic [2:0][IW-1:0] d;
    logic [2:0][IW-1:0] n;
    logic [2:0][IW-1:0] absr;
    logic [2:0]         rs;
    logic [IW-1:0]      num;
    logic [IW-1:0]      den;
    logic               sat;
    logic [CI_W-1:0]    ci;
  } side_a_t;

  typedef struct packed {
    logic [2:0][IW-1:0] d;
    logic [2:0][IW-1:0] n;
    logic [2:0]         rs;
    logic [IW-1:0]      num;
    logic [IW-1:0]      den;
    logic               sat;
    logic [CI_W-1:0]    ci;
    logic               lenz;
  } side_b_t;

  typedef struct packed {
    logic [2:0][IW-1:0]   d;
    logic [2:0][IW-1:0]   n;
    logic [CI_W-1:0]      ci;
    logic [2:0][RN_W-1:0] rn;
    logic                 sat;
  } side_c_t;

  typedef struct packed {
    logic                 tir;
    logic [RC_W-1:0]      rc;
    logic [2:0][DR_W-1:0] dr;
    logic [2:0][RR_W-1:0] rr;
    logic [2:0][IW-1:0]   n;
  } side_e_t;

  // configuration registers
  logic [15:0] material_index;
  logic [14:0] roughness;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      material_index <= srd_pkg::MATERIAL_RESET;
      roughness      <= srd_pkg::ROUGH_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        srd_pkg::REG_MATERIAL: material_index <= pwdata[15:0];
        srd_pkg::REG_ROUGH:    roughness      <= pwdata[14:0];
        default:               material_index <= material_index;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      srd_pkg::REG_MATERIAL: prdata = 32'(material_index);
      srd_pkg::REG_ROUGH:    prdata = 32'(roughness);
      default:               prdata = '0;
    endcase
  end

  // pipeline advance
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // stage 1: capture the request
  logic              v1;
  logic signed [IW-1:0] d1 [3];
  logic signed [IW-1:0] n1 [3];
  logic signed [IW-1:0] r1 [3];
  logic              ff1;
  logic [IW-1:0]     cur1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1[0] <= dir_x;   d1[1] <= dir_y;   d1[2] <= dir_z;
      n1[0] <= norm_x;  n1[1] <= norm_y;  n1[2] <= norm_z;
      r1[0] <= rand_x;  r1[1] <= rand_y;  r1[2] <= rand_z;
      ff1   <= front_face;
      cur1  <= current_index;
    end
  end

  // stage 2: squares, dot terms, index ratio operands
  logic signed [2*IW-1:0] rsq [3];
  logic signed [2*IW-1:0] dnp [3];
  logic [IW-1:0]          num_s, den_raw, den_s;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rsq[i] = r1[i] * r1[i];
      dnp[i] = d1[i] * n1[i];
    end
    num_s   = ff1 ? cur1 : material_index;
    den_raw = ff1 ? material_index : cur1;
    den_s   = (den_raw == '0) ? IW'(1) : den_raw;
  end

  logic                   v2;
  logic [2*IW-2:0]        rr2 [3];
  logic signed [2*IW-1:0] dn2 [3];
  logic [2:0][IW-1:0]     d2, n2, absr2;
  logic [2:0]             rs2;
  logic [IW-1:0]          num2, den2;
  logic                   sat2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        rr2[i]   <= rsq[i][2*IW-2:0];
        dn2[i]   <= dnp[i];
        d2[i]    <= d1[i];
        n2[i]    <= n1[i];
        absr2[i] <= r1[i][IW-1] ? IW'(-r1[i]) : r1[i];
        rs2[i]   <= r1[i][IW-1];
      end
      num2 <= num_s;
      den2 <= den_s;
      sat2 <= ({4'b0000, num_s} >= {den_s, 4'b0000});
    end
  end

  // stage 3: length squared and cos_i
  logic signed [DOT_W-1:0] dot3;
  logic signed [DOT_W:0]   ndot3;
  logic                    v3;
  logic [2*IW-1:0]         len2_3;
  side_a_t                 sa3;

  always_comb begin
    dot3  = dn2[0] + dn2[1] + dn2[2];
    ndot3 = -dot3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      len2_3   <= (2*IW)'(rr2[0]) + (2*IW)'(rr2[1]) + (2*IW)'(rr2[2]);
      sa3.d    <= d2;
      sa3.n    <= n2;
      sa3.absr <= absr2;
      sa3.rs   <= rs2;
      sa3.num  <= num2;
      sa3.den  <= den2;
      sa3.sat  <= sat2;
      sa3.ci   <= ndot3[DOT_W:F];
    end
  end

  // length of the random vector
  srd_pkg::pipe_ctl_t ctl_len;
  logic               v_len;
  logic [IW-1:0]      len;
  side_a_t            sa_len;

  assign ctl_len.en    = en;
  assign ctl_len.valid = v3;

  srd_sqrt #(
    .VW (2*IW),
    .SW ($bits(side_a_t))
  ) u_len_sqrt (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl_len),
    .val       (len2_3),
    .side_in   (sa3),
    .valid_out (v_len),
    .root      (len),
    .side_out  (sa_len)
  );

  // normalize the random vector
  srd_pkg::pipe_ctl_t       ctl_rn;
  logic [2:0][IW+F-1:0]     rn_num;
  side_b_t                  sb_in, sb_out;
  logic                     v_rn;
  logic [2:0][F:0]          rn_q;

  assign ctl_rn.en    = en;
  assign ctl_rn.valid = v_len;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rn_num[i] = {sa_len.absr[i], {F{1'b0}}};
    end
    sb_in.d    = sa_len.d;
    sb_in.n    = sa_len.n;
    sb_in.rs   = sa_len.rs;
    sb_in.num  = sa_len.num;
    sb_in.den  = sa_len.den;
    sb_in.sat  = sa_len.sat;
    sb_in.ci   = sa_len.ci;
    sb_in.lenz = (len == '0);
  end

  srd_div #(
    .NW    (IW + F),
    .DW    (IW),
    .QW    (F + 1),
    .LANES (3),
    .SW    ($bits(side_b_t))
  ) u_rn_div (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl_rn),
    .num       (rn_num),
    .den       (len),
    .side_in   (sb_in),
    .valid_out (v_rn),
    .quo       (rn_q),
    .side_out  (sb_out)
  );

  // index ratio
  srd_pkg::pipe_ctl_t      ctl_rt;
  logic [0:0][IW+F-1:0]    rt_num;
  side_c_t                 sc_in, sc_out;
  logic                    v_rt;
  logic [0:0][RATIO_W-1:0] rt_q;

  assign ctl_rt.en    = en;
  assign ctl_rt.valid = v_rn;

  always_comb begin
    rt_num[0] = {sb_out.num, {F{1'b0}}};
    sc_in.d   = sb_out.d;
    sc_in.n   = sb_out.n;
    sc_in.ci  = sb_out.ci;
    sc_in.sat = sb_out.sat;
    for (int i = 0; i < 3; i++) begin
      if (sb_out.lenz) begin
        sc_in.rn[i] = '0;
      end else if (sb_out.rs[i]) begin
        sc_in.rn[i] = -RN_W'({1'b0, rn_q[i]});
      end else begin
        sc_in.rn[i] = RN_W'({1'b0, rn_q[i]});
      end
    end
  end

  srd_div #(
    .NW    (IW + F),
    .DW    (IW),
    .QW    (RATIO_W),
    .LANES (1),
    .SW    ($bits(side_c_t))
  ) u_ratio_div (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl_rt),
    .num       (rt_num),
    .den       (sb_out.den),
    .side_in   (sc_in),
    .valid_out (v_rt),
    .quo       (rt_q),
    .side_out  (sc_out)
  );

  // products on the ratio, cos_i and the random vector
  logic [RATIO_W-1:0] ratio;
  assign ratio = sc_out.sat ? '1 : rt_q[0];

  logic                    p2_v;
  logic [2*RATIO_W-1:0]    r2p;
  logic signed [2*CI_W-1:0] cisqp;
  logic signed [RCP_W-1:0] rcp;
  logic signed [DRP_W-1:0] drp [3];
  logic signed [RRP_W-1:0] rrp [3];
  logic [2:0][IW-1:0]      p2_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_v <= 1'b0;
    end else if (en) begin
      p2_v <= v_rt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r2p   <= ratio * ratio;
      cisqp <= $signed(sc_out.ci) * $signed(sc_out.ci);
      rcp   <= $signed({1'b0, ratio}) * $signed(sc_out.ci);
      for (int i = 0; i < 3; i++) begin
        drp[i] <= $signed(sc_out.d[i]) * $signed({1'b0, ratio});
        rrp[i] <= $signed(sc_out.rn[i]) * $signed({1'b0, roughness});
      end
      p2_n <= sc_out.n;
    end
  end

  // 1 - cos_i^2 and ratio^2
  logic                 p3_v;
  logic [R2_W-1:0]      r2;
  logic signed [OM_W-1:0] om;
  side_e_t              p3_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_v <= 1'b0;
    end else if (en) begin
      p3_v <= p2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r2      <= r2p[2*RATIO_W-1:F];
      om      <= ONE_OM - OM_W'($signed(cisqp[2*CI_W-1:F]));
      p3_e.tir <= 1'b0;
      p3_e.rc <= rcp[RCP_W-1:F];
      for (int i = 0; i < 3; i++) begin
        p3_e.dr[i] <= drp[i][DRP_W-1:F];
        p3_e.rr[i] <= rrp[i][RRP_W-1:F];
      end
      p3_e.n <= p2_n;
    end
  end

  // sin2_t product
  logic                   p4_v;
  logic signed [SP_W-1:0] sp;
  side_e_t                p4_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      p4_v <= 1'b0;
    end else if (en) begin
      p4_v <= p3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sp   <= $signed({1'b0, r2}) * om;
      p4_e <= p3_e;
    end
  end

  // total internal reflection test and 1 - sin2_t
  logic signed [S_W-1:0] sin2;
  logic                  p5_v;
  logic [S_W-1:0]        diff5;
  side_e_t               p5_e;

  assign sin2 = sp[SP_W-1:F];

  always_ff @(posedge clk) begin
    if (rst) begin
      p5_v <= 1'b0;
    end else if (en) begin
      p5_v <= p4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff5 <= S_W'(ONE_S - sin2);
      p5_e  <= '{tir: (sin2 > ONE_S), rc: p4_e.rc, dr: p4_e.dr, rr: p4_e.rr, n: p4_e.n};
    end
  end

  // cos_t root
  srd_pkg::pipe_ctl_t ctl_ct;
  logic               v_ct;
  logic [CT_W-1:0]    cos_t;
  side_e_t            se_ct;

  assign ctl_ct.en    = en;
  assign ctl_ct.valid = p5_v;

  srd_sqrt #(
    .VW (SQ_W),
    .SW ($bits(side_e_t))
  ) u_cos_sqrt (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl_ct),
    .val       ({diff5, {F{1'b0}}}),
    .side_in   (p5_e),
    .valid_out (v_ct),
    .root      (cos_t),
    .side_out  (se_ct)
  );

  // normal coefficient
  logic                  q1_v;
  logic signed [K_W-1:0] k1;
  side_e_t               q1_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      q1_v <= 1'b0;
    end else if (en) begin
      q1_v <= v_ct;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k1   <= K_W'($signed(se_ct.rc)) - K_W'($signed({1'b0, cos_t}));
      q1_e <= se_ct;
    end
  end

  // normal term products
  logic                    q2_v;
  logic signed [NKP_W-1:0] nkp [3];
  side_e_t                 q2_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      q2_v <= 1'b0;
    end else if (en) begin
      q2_v <= q1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        nkp[i] <= $signed(q1_e.n[i]) * k1;
      end
      q2_e <= q1_e;
    end
  end

  // sum and saturate
  function automatic logic [OW-1:0] sat_out(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-OW:0] hi;
    hi = v[SUM_W-1:OW-1];
    if (hi == '0 || hi == '1) begin
      sat_out = v[OW-1:0];
    end else if (v[SUM_W-1]) begin
      sat_out = {1'b1, {(OW-1){1'b0}}};
    end else begin
      sat_out = {1'b0, {(OW-1){1'b1}}};
    end
  endfunction

  logic signed [SUM_W-1:0] sum [3];
  logic [OW-1:0]           res [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = SUM_W'($signed(nkp[i][NKP_W-1:F]))
             + SUM_W'($signed(q2_e.dr[i]))
             + SUM_W'($signed(q2_e.rr[i]));
      res[i] = q2_e.tir ? '0 : sat_out(sum[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= q2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x        <= res[0];
      out_y        <= res[1];
      out_z        <= res[2];
      refracted_ok <= !q2_e.tir;
    end
  end

  // checks
  a_tir_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !refracted_ok |-> out_x == '0 && out_y == '0 && out_z == '0)
    else $error("reflected result carries a nonzero direction");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while the result is stalled");

endmodule
